[rtl/dms_pkg.sv]
// shared types, codes and reset constants for the door motor sequencer
package dms_pkg;

    localparam int TIME_BITS_DEF = 16;
    localparam int CFG_W         = 16;
    localparam int SENS_W        = 3;
    localparam int KIND_W        = 3;
    localparam int PHASE_W       = 3;
    localparam int COVER_W       = 3;
    localparam int REG_IDX_W     = 3;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_TICK   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_OPEN   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CLOSE  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_STOP   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_TOGGLE = 3'd4;
    localparam logic [KIND_W-1:0] KIND_PRESS  = 3'd5;

    // sequencer phases
    localparam logic [PHASE_W-1:0] PH_IDLE        = 3'd0;
    localparam logic [PHASE_W-1:0] PH_OPENING     = 3'd1;
    localparam logic [PHASE_W-1:0] PH_CLOSING     = 3'd2;
    localparam logic [PHASE_W-1:0] PH_STOPPED     = 3'd3;
    localparam logic [PHASE_W-1:0] PH_START_OPEN  = 3'd4;
    localparam logic [PHASE_W-1:0] PH_START_CLOSE = 3'd5;

    // cover codes
    localparam logic [COVER_W-1:0] COVER_OPENING = 3'd0;
    localparam logic [COVER_W-1:0] COVER_CLOSING = 3'd1;
    localparam logic [COVER_W-1:0] COVER_CLOSED  = 3'd2;
    localparam logic [COVER_W-1:0] COVER_OPEN    = 3'd3;
    localparam logic [COVER_W-1:0] COVER_STOPPED = 3'd4;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_RELAY_DELAY = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_MAX_MOVE    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_OVERRUN     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_GUARD       = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_BLINK       = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SENSOR_EN   = 3'd5;

    // register reset values
    localparam logic [CFG_W-1:0]  RELAY_DELAY_RST = 16'd500;
    localparam logic [CFG_W-1:0]  MAX_MOVE_RST    = 16'd30000;
    localparam logic [CFG_W-1:0]  OVERRUN_RST     = 16'd1000;
    localparam logic [CFG_W-1:0]  GUARD_RST       = 16'd1000;
    localparam logic [CFG_W-1:0]  BLINK_RST       = 16'd300;
    localparam logic [SENS_W-1:0] SENSOR_EN_RST   = 3'd1;

    typedef struct packed {
        logic [CFG_W-1:0]  relay_delay_ms;
        logic [CFG_W-1:0]  max_move_ms;
        logic [CFG_W-1:0]  overrun_ms;
        logic [CFG_W-1:0]  guard_ms;
        logic [CFG_W-1:0]  blink_half_ms;
        logic [SENS_W-1:0] sensor_enable;
    } cfg_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic               in_motion;
        logic               last_dir_open;
        logic               runon_active;
        logic               blink_level;
        logic               power_on;
        logic               dir_up;
    } ctrl_t;

    typedef struct packed {
        logic               power_relay;
        logic               dir_relay;
        logic               status_light;
        logic               locked_light;
        logic               moving;
        logic [COVER_W-1:0] cover_code;
    } res_t;

endpackage

[rtl/dms_step.sv]
// next-state and result logic for one item of the door motor sequencer
module dms_step #(
    parameter int TIME_BITS = dms_pkg::TIME_BITS_DEF
) (
    input  logic [dms_pkg::KIND_W-1:0] kind,
    input  logic                       closed_hit,
    input  logic                       open_hit,
    input  logic                       blocked,
    input  dms_pkg::cfg_t              cfg,
    input  dms_pkg::ctrl_t             ctrl,
    input  logic [TIME_BITS-1:0]       run_time,
    input  logic [TIME_BITS-1:0]       runon_time,
    input  logic [TIME_BITS-1:0]       since_change,
    input  logic [TIME_BITS-1:0]       blink_time,
    output dms_pkg::ctrl_t             ctrl_next,
    output logic [TIME_BITS-1:0]       run_time_next,
    output logic [TIME_BITS-1:0]       runon_time_next,
    output logic [TIME_BITS-1:0]       since_change_next,
    output logic [TIME_BITS-1:0]       blink_time_next,
    output dms_pkg::res_t              res
);

    localparam int CW = (TIME_BITS > dms_pkg::CFG_W) ? TIME_BITS : dms_pkg::CFG_W;
    localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};
    localparam logic [TIME_BITS-1:0] TONE = TIME_BITS'(1);

    logic cl_e;
    logic op_e;
    logic bl_e;

    assign cl_e = closed_hit & cfg.sensor_enable[0];
    assign op_e = open_hit   & cfg.sensor_enable[1];
    assign bl_e = blocked    & cfg.sensor_enable[2];

    always_comb
    begin
        dms_pkg::ctrl_t       c;
        logic [TIME_BITS-1:0] rt;
        logic [TIME_BITS-1:0] rot;
        logic [TIME_BITS-1:0] sc;
        logic [TIME_BITS-1:0] bt;
        logic                 tog;
        logic                 do_open;
        logic                 do_close;
        logic                 do_halt;
        logic                 do_arm;
        logic                 arm_up;
        logic                 halt_s;
        logic                 closing;
        logic                 opening;

        c        = ctrl;
        rt       = run_time;
        rot      = runon_time;
        sc       = since_change;
        bt       = blink_time;
        tog      = 1'b0;
        do_open  = 1'b0;
        do_close = 1'b0;
        do_halt  = 1'b0;
        do_arm   = 1'b0;
        arm_up   = 1'b0;
        halt_s   = 1'b0;

        case (kind)
            dms_pkg::KIND_TICK:
            begin
                rt = (rt == TMAX) ? rt : rt + TONE;
                if (c.runon_active)
                begin
                    rot = (rot == TMAX) ? rot : rot + TONE;
                end
                sc = (sc == TMAX) ? sc : sc + TONE;
                bt = (bt == TMAX) ? bt : bt + TONE;
            end
            dms_pkg::KIND_OPEN:   do_open = 1'b1;
            dms_pkg::KIND_CLOSE:  do_close = 1'b1;
            dms_pkg::KIND_STOP:   do_halt = 1'b1;
            dms_pkg::KIND_TOGGLE: tog = 1'b1;
            dms_pkg::KIND_PRESS:  tog = (CW'(sc) >= CW'(cfg.guard_ms));
            default:              tog = 1'b0;
        endcase

        if (tog)
        begin
            if (c.in_motion)
            begin
                do_halt = 1'b1;
            end
            else if (cl_e)
            begin
                do_open = 1'b1;
            end
            else if (op_e)
            begin
                do_close = 1'b1;
            end
            else if (c.last_dir_open)
            begin
                do_close = 1'b1;
            end
            else
            begin
                do_open = 1'b1;
            end
        end

        if (do_open)
        begin
            c.last_dir_open = 1'b1;
            do_arm          = !op_e;
            arm_up          = 1'b1;
        end
        if (do_close)
        begin
            c.last_dir_open = 1'b0;
            do_arm          = !(cl_e || bl_e);
            arm_up          = 1'b0;
        end

        if (do_arm)
        begin
            c.runon_active = 1'b0;
            rot            = '0;
            c.phase        = arm_up ? dms_pkg::PH_START_OPEN : dms_pkg::PH_START_CLOSE;
            c.in_motion    = 1'b1;
            rt             = '0;
            sc             = '0;
            c.dir_up       = arm_up;
            c.power_on     = 1'b0;
        end
        if (do_halt)
        begin
            c.power_on     = 1'b0;
            c.dir_up       = 1'b0;
            c.in_motion    = 1'b0;
            c.phase        = dms_pkg::PH_STOPPED;
            sc             = '0;
            c.runon_active = 1'b0;
            rot            = '0;
        end

        // relay start after the delay
        if (c.in_motion && (c.phase == dms_pkg::PH_START_OPEN ||
            c.phase == dms_pkg::PH_START_CLOSE) &&
            (CW'(rt) >= CW'(cfg.relay_delay_ms)))
        begin
            c.power_on = 1'b1;
            c.phase    = (c.phase == dms_pkg::PH_START_OPEN) ?
                         dms_pkg::PH_OPENING : dms_pkg::PH_CLOSING;
        end

        // safety checks
        closing = (c.phase == dms_pkg::PH_CLOSING) || (c.phase == dms_pkg::PH_START_CLOSE);
        opening = (c.phase == dms_pkg::PH_OPENING) || (c.phase == dms_pkg::PH_START_OPEN);
        if (c.in_motion)
        begin
            if (closing && bl_e)
            begin
                halt_s = 1'b1;
            end
            else if (closing && cl_e)
            begin
                if (!c.runon_active && (cfg.overrun_ms != '0))
                begin
                    c.runon_active = 1'b1;
                    rot            = '0;
                end
                else if (!(c.runon_active && (CW'(rot) < CW'(cfg.overrun_ms))))
                begin
                    halt_s = 1'b1;
                end
            end
            else if (opening && op_e)
            begin
                halt_s = 1'b1;
            end
        end
        if (halt_s)
        begin
            c.power_on     = 1'b0;
            c.dir_up       = 1'b0;
            c.in_motion    = 1'b0;
            c.phase        = bl_e && closing ? dms_pkg::PH_STOPPED : dms_pkg::PH_IDLE;
            sc             = '0;
            c.runon_active = 1'b0;
            rot            = '0;
        end

        // move-time limit
        if (c.in_motion && (CW'(rt) >= CW'(cfg.max_move_ms)))
        begin
            c.power_on     = 1'b0;
            c.dir_up       = 1'b0;
            c.in_motion    = 1'b0;
            c.phase        = dms_pkg::PH_STOPPED;
            sc             = '0;
            c.runon_active = 1'b0;
            rot            = '0;
        end

        // status light blink
        if (c.in_motion && (CW'(bt) >= CW'(cfg.blink_half_ms)))
        begin
            bt            = '0;
            c.blink_level = !c.blink_level;
        end

        if (c.in_motion && (c.phase == dms_pkg::PH_OPENING ||
            c.phase == dms_pkg::PH_START_OPEN))
        begin
            res.cover_code = dms_pkg::COVER_OPENING;
        end
        else if (c.in_motion && (c.phase == dms_pkg::PH_CLOSING ||
                 c.phase == dms_pkg::PH_START_CLOSE))
        begin
            res.cover_code = dms_pkg::COVER_CLOSING;
        end
        else if (cl_e)
        begin
            res.cover_code = dms_pkg::COVER_CLOSED;
        end
        else if (op_e)
        begin
            res.cover_code = dms_pkg::COVER_OPEN;
        end
        else if (c.phase == dms_pkg::PH_STOPPED)
        begin
            res.cover_code = dms_pkg::COVER_STOPPED;
        end
        else
        begin
            res.cover_code = dms_pkg::COVER_OPEN;
        end

        res.power_relay  = c.power_on;
        res.dir_relay    = c.dir_up;
        res.status_light = c.in_motion ? c.blink_level : 1'b1;
        res.locked_light = cl_e;
        res.moving       = c.in_motion;

        ctrl_next         = c;
        run_time_next     = rt;
        runon_time_next   = rot;
        since_change_next = sc;
        blink_time_next   = bt;
    end

endmodule

[rtl/door_motor_sequencer.sv]
// door motor sequencer top level: input register, state update, result register
//
//  channel   signals                                   direction
//  in        in_valid in_ready kind closed_hit          into block
//            open_hit blocked
//  out       out_valid out_ready power_relay dir_relay  out of block
//            status_light locked_light moving cover_code
//  cfg       cfg_valid cfg_ready cfg_index cfg_data     into block
//
//  an item waits in the input register; the state update is combinational, so its
//  result is registered when the item advances; one item per cycle sustained unless
//  the result register stalls; the single-pass state update sets the rate
//  reset clears state and loads the register defaults; cfg_ready is always high
//  a stalled result register holds the next item in the input register
module door_motor_sequencer #(
    parameter int TIME_BITS = dms_pkg::TIME_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [dms_pkg::KIND_W-1:0]    kind,
    input  logic                          closed_hit,
    input  logic                          open_hit,
    input  logic                          blocked,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          power_relay,
    output logic                          dir_relay,
    output logic                          status_light,
    output logic                          locked_light,
    output logic                          moving,
    output logic [dms_pkg::COVER_W-1:0]   cover_code,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [dms_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [dms_pkg::CFG_W-1:0]     cfg_data
);

    dms_pkg::cfg_t  cfg_reg;
    dms_pkg::ctrl_t ctrl_reg;
    dms_pkg::ctrl_t ctrl_next;
    dms_pkg::res_t  res_reg;
    dms_pkg::res_t  res_next;

    logic                       in_valid_reg;
    logic [dms_pkg::KIND_W-1:0] kind_reg;
    logic                       closed_hit_reg;
    logic                       open_hit_reg;
    logic                       blocked_reg;
    logic                       out_valid_reg;
    logic                       advance;

    logic [TIME_BITS-1:0] run_time_reg;
    logic [TIME_BITS-1:0] runon_time_reg;
    logic [TIME_BITS-1:0] since_change_reg;
    logic [TIME_BITS-1:0] blink_time_reg;
    logic [TIME_BITS-1:0] run_time_next;
    logic [TIME_BITS-1:0] runon_time_next;
    logic [TIME_BITS-1:0] since_change_next;
    logic [TIME_BITS-1:0] blink_time_next;

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.relay_delay_ms <= dms_pkg::RELAY_DELAY_RST;
            cfg_reg.max_move_ms    <= dms_pkg::MAX_MOVE_RST;
            cfg_reg.overrun_ms     <= dms_pkg::OVERRUN_RST;
            cfg_reg.guard_ms       <= dms_pkg::GUARD_RST;
            cfg_reg.blink_half_ms  <= dms_pkg::BLINK_RST;
            cfg_reg.sensor_enable  <= dms_pkg::SENSOR_EN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                dms_pkg::REG_RELAY_DELAY: cfg_reg.relay_delay_ms <= cfg_data;
                dms_pkg::REG_MAX_MOVE:    cfg_reg.max_move_ms    <= cfg_data;
                dms_pkg::REG_OVERRUN:     cfg_reg.overrun_ms     <= cfg_data;
                dms_pkg::REG_GUARD:       cfg_reg.guard_ms       <= cfg_data;
                dms_pkg::REG_BLINK:       cfg_reg.blink_half_ms  <= cfg_data;
                dms_pkg::REG_SENSOR_EN:
                    cfg_reg.sensor_enable <= cfg_data[dms_pkg::SENS_W-1:0];
                default:                  cfg_reg <= cfg_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            kind_reg       <= kind;
            closed_hit_reg <= closed_hit;
            open_hit_reg   <= open_hit;
            blocked_reg    <= blocked;
        end
    end

    dms_step #(
        .TIME_BITS (TIME_BITS)
    ) u_step (
        .kind              (kind_reg),
        .closed_hit        (closed_hit_reg),
        .open_hit          (open_hit_reg),
        .blocked           (blocked_reg),
        .cfg               (cfg_reg),
        .ctrl              (ctrl_reg),
        .run_time          (run_time_reg),
        .runon_time        (runon_time_reg),
        .since_change      (since_change_reg),
        .blink_time        (blink_time_reg),
        .ctrl_next         (ctrl_next),
        .run_time_next     (run_time_next),
        .runon_time_next   (runon_time_next),
        .since_change_next (since_change_next),
        .blink_time_next   (blink_time_next),
        .res               (res_next)
    );

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg.phase         <= dms_pkg::PH_IDLE;
            ctrl_reg.in_motion     <= 1'b0;
            ctrl_reg.last_dir_open <= 1'b0;
            ctrl_reg.runon_active  <= 1'b0;
            ctrl_reg.blink_level   <= 1'b0;
            ctrl_reg.power_on      <= 1'b0;
            ctrl_reg.dir_up        <= 1'b0;
            run_time_reg           <= '0;
            runon_time_reg         <= '0;
            since_change_reg       <= '0;
            blink_time_reg         <= '0;
        end
        else if (advance)
        begin
            ctrl_reg         <= ctrl_next;
            run_time_reg     <= run_time_next;
            runon_time_reg   <= runon_time_next;
            since_change_reg <= since_change_next;
            blink_time_reg   <= blink_time_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign power_relay  = res_reg.power_relay;
    assign dir_relay    = res_reg.dir_relay;
    assign status_light = res_reg.status_light;
    assign locked_light = res_reg.locked_light;
    assign moving       = res_reg.moving;
    assign cover_code   = res_reg.cover_code;

    // power only with motion in progress
    a_power_needs_motion: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_reg.power_on |-> ctrl_reg.in_motion)
        else $error("power relay on without motion");

    // direction relay released whenever the door rests
    a_dir_released: assert property (@(posedge clk) disable iff (!rst_n)
        !ctrl_reg.in_motion |-> !ctrl_reg.dir_up)
        else $error("direction relay held while idle");

    // a moving result reports opening or closing
    a_moving_cover: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && moving) |->
            (cover_code == dms_pkg::COVER_OPENING || cover_code == dms_pkg::COVER_CLOSING))
        else $error("moving result with resting cover code");

    // input only stalls behind a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (in_valid_reg && out_valid_reg && !out_ready))
        else $error("input stalled without a held result");

endmodule

[sim/tb_top.sv]
// testbench for the door motor sequencer: predicts each result per item and checks it field by field
module tb_top;

    localparam int TB_TIME_BITS = dms_pkg::TIME_BITS_DEF;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES = 200;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_PRINTED = 40;
    localparam int LONG_TICKS = 20;

    // kinds that carry no command; the block still runs its checks on them
    localparam logic [dms_pkg::KIND_W-1:0] KIND_SPARE_A = 3'd6;
    localparam logic [dms_pkg::KIND_W-1:0] KIND_SPARE_B = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic [dms_pkg::KIND_W-1:0]    kind = dms_pkg::KIND_TICK;
    logic                          closed_hit = 1'b0;
    logic                          open_hit = 1'b0;
    logic                          blocked = 1'b0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic                          power_relay;
    logic                          dir_relay;
    logic                          status_light;
    logic                          locked_light;
    logic                          moving;
    logic [dms_pkg::COVER_W-1:0]   cover_code;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [dms_pkg::REG_IDX_W-1:0] cfg_index = dms_pkg::REG_RELAY_DELAY;
    logic [dms_pkg::CFG_W-1:0]     cfg_data = '0;

    // door state as predicted
    dms_pkg::cfg_t               sq_cfg;
    logic [dms_pkg::PHASE_W-1:0] sq_phase;
    logic                        sq_moving;
    logic                        sq_last_open;
    logic                        sq_runon;
    logic                        sq_blink;
    logic                        sq_power;
    logic                        sq_up;
    logic [TB_TIME_BITS-1:0]     sq_run_t;
    logic [TB_TIME_BITS-1:0]     sq_runon_t;
    logic [TB_TIME_BITS-1:0]     sq_since_t;
    logic [TB_TIME_BITS-1:0]     sq_blink_t;

    dms_pkg::res_t expected_outputs[$];
    dms_pkg::res_t want_res;

    int errors = 0;
    int idle_cycles = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int holds_asked = 0;

    door_motor_sequencer DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .closed_hit   (closed_hit),
        .open_hit     (open_hit),
        .blocked      (blocked),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .power_relay  (power_relay),
        .dir_relay    (dir_relay),
        .status_light (status_light),
        .locked_light (locked_light),
        .moving       (moving),
        .cover_code   (cover_code),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void reset_door();
        sq_cfg.relay_delay_ms = dms_pkg::RELAY_DELAY_RST;
        sq_cfg.max_move_ms    = dms_pkg::MAX_MOVE_RST;
        sq_cfg.overrun_ms     = dms_pkg::OVERRUN_RST;
        sq_cfg.guard_ms       = dms_pkg::GUARD_RST;
        sq_cfg.blink_half_ms  = dms_pkg::BLINK_RST;
        sq_cfg.sensor_enable  = dms_pkg::SENSOR_EN_RST;
        sq_phase     = dms_pkg::PH_IDLE;
        sq_moving    = 1'b0;
        sq_last_open = 1'b0;
        sq_runon     = 1'b0;
        sq_blink     = 1'b0;
        sq_power     = 1'b0;
        sq_up        = 1'b0;
        sq_run_t     = '0;
        sq_runon_t   = '0;
        sq_since_t   = '0;
        sq_blink_t   = '0;
    endfunction

    function automatic void write_door_reg(input logic [dms_pkg::REG_IDX_W-1:0] idx,
                                           input logic [dms_pkg::CFG_W-1:0] value);
        case (idx)
            dms_pkg::REG_RELAY_DELAY: sq_cfg.relay_delay_ms = value;
            dms_pkg::REG_MAX_MOVE:    sq_cfg.max_move_ms = value;
            dms_pkg::REG_OVERRUN:     sq_cfg.overrun_ms = value;
            dms_pkg::REG_GUARD:       sq_cfg.guard_ms = value;
            dms_pkg::REG_BLINK:       sq_cfg.blink_half_ms = value;
            dms_pkg::REG_SENSOR_EN:   sq_cfg.sensor_enable = value[dms_pkg::SENS_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic logic [TB_TIME_BITS-1:0] sat_step(input logic [TB_TIME_BITS-1:0] v);
        return (v == '1) ? v : v + TB_TIME_BITS'(1);
    endfunction

    function automatic void stop_door();
        sq_power   = 1'b0;
        sq_up      = 1'b0;
        sq_moving  = 1'b0;
        sq_phase   = dms_pkg::PH_STOPPED;
        sq_since_t = '0;
        sq_runon   = 1'b0;
        sq_runon_t = '0;
    endfunction

    function automatic void start_door(input logic upward);
        sq_runon   = 1'b0;
        sq_runon_t = '0;
        sq_phase   = upward ? dms_pkg::PH_START_OPEN : dms_pkg::PH_START_CLOSE;
        sq_moving  = 1'b1;
        sq_run_t   = '0;
        sq_since_t = '0;
        sq_up      = upward;
        sq_power   = 1'b0;
    endfunction

    function automatic void req_open(input logic op);
        sq_last_open = 1'b1;
        if (!op)
            start_door(1'b1);
    endfunction

    function automatic void req_close(input logic cl, input logic bl);
        sq_last_open = 1'b0;
        if (!cl && !bl)
            start_door(1'b0);
    endfunction

    function automatic void req_toggle(input logic cl, input logic op, input logic bl);
        if (sq_moving)
            stop_door();
        else if (cl)
            req_open(op);
        else if (op)
            req_close(cl, bl);
        else if (sq_last_open)
            req_close(cl, bl);
        else
            req_open(op);
    endfunction

    function automatic void check_safety(input logic cl, input logic op, input logic bl);
        logic closing;
        logic opening;
        closing = (sq_phase == dms_pkg::PH_CLOSING) || (sq_phase == dms_pkg::PH_START_CLOSE);
        opening = (sq_phase == dms_pkg::PH_OPENING) || (sq_phase == dms_pkg::PH_START_OPEN);
        if (sq_moving)
        begin
            if (closing && bl)
                stop_door();
            else if (closing && cl)
            begin
                // run-on starts on the first sight of the closed endstop
                if (!sq_runon && sq_cfg.overrun_ms != 0)
                begin
                    sq_runon   = 1'b1;
                    sq_runon_t = '0;
                end
                else if (!(sq_runon && sq_runon_t < sq_cfg.overrun_ms))
                begin
                    stop_door();
                    sq_phase = dms_pkg::PH_IDLE;
                end
            end
            else if (opening && op)
            begin
                stop_door();
                sq_phase = dms_pkg::PH_IDLE;
            end
        end
    endfunction

    function automatic dms_pkg::res_t step_door(input logic [dms_pkg::KIND_W-1:0] k,
                                                input logic ch, input logic oh,
                                                input logic bk);
        logic cl;
        logic op;
        logic bl;
        dms_pkg::res_t r;
        cl = ch & sq_cfg.sensor_enable[0];
        op = oh & sq_cfg.sensor_enable[1];
        bl = bk & sq_cfg.sensor_enable[2];
        case (k)
            dms_pkg::KIND_TICK:
            begin
                sq_run_t = sat_step(sq_run_t);
                if (sq_runon)
                    sq_runon_t = sat_step(sq_runon_t);
                sq_since_t = sat_step(sq_since_t);
                sq_blink_t = sat_step(sq_blink_t);
            end
            dms_pkg::KIND_OPEN:   req_open(op);
            dms_pkg::KIND_CLOSE:  req_close(cl, bl);
            dms_pkg::KIND_STOP:   stop_door();
            dms_pkg::KIND_TOGGLE: req_toggle(cl, op, bl);
            dms_pkg::KIND_PRESS:
            begin
                if (sq_since_t >= sq_cfg.guard_ms)
                    req_toggle(cl, op, bl);
            end
            default: ;
        endcase

        if (sq_moving && (sq_phase == dms_pkg::PH_START_OPEN ||
            sq_phase == dms_pkg::PH_START_CLOSE) && sq_run_t >= sq_cfg.relay_delay_ms)
        begin
            sq_power = 1'b1;
            sq_phase = (sq_phase == dms_pkg::PH_START_OPEN) ?
                       dms_pkg::PH_OPENING : dms_pkg::PH_CLOSING;
        end
        check_safety(cl, op, bl);
        if (sq_moving && sq_run_t >= sq_cfg.max_move_ms)
            stop_door();
        if (sq_moving && sq_blink_t >= sq_cfg.blink_half_ms)
        begin
            sq_blink_t = '0;
            sq_blink   = ~sq_blink;
        end

        if (sq_moving && (sq_phase == dms_pkg::PH_OPENING ||
            sq_phase == dms_pkg::PH_START_OPEN))
            r.cover_code = dms_pkg::COVER_OPENING;
        else if (sq_moving && (sq_phase == dms_pkg::PH_CLOSING ||
                 sq_phase == dms_pkg::PH_START_CLOSE))
            r.cover_code = dms_pkg::COVER_CLOSING;
        else if (cl)
            r.cover_code = dms_pkg::COVER_CLOSED;
        else if (op)
            r.cover_code = dms_pkg::COVER_OPEN;
        else if (sq_phase == dms_pkg::PH_STOPPED)
            r.cover_code = dms_pkg::COVER_STOPPED;
        else
            r.cover_code = dms_pkg::COVER_OPEN;
        r.power_relay  = sq_power;
        r.dir_relay    = sq_up;
        r.status_light = sq_moving ? sq_blink : 1'b1;
        r.locked_light = cl;
        r.moving       = sq_moving;
        return r;
    endfunction

    task automatic report_error(input string what, input int got, input int want);
        errors++;
        if (errors <= MAX_PRINTED)
            $display("%0t: %s got %0d expected %0d", $time, what, got, want);
    endtask

    // predict on each input transfer, then check each result transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                write_door_reg(cfg_index, cfg_data);
            if (in_valid && in_ready)
                expected_outputs.push_back(step_door(kind, closed_hit, open_hit, blocked));
            if (out_valid && out_ready)
            begin
                if (expected_outputs.size() == 0)
                    report_error("unexpected result, cover_code", cover_code, 0);
                else
                begin
                    want_res = expected_outputs.pop_front();
                    if (power_relay !== want_res.power_relay)
                        report_error("power_relay", power_relay, want_res.power_relay);
                    if (dir_relay !== want_res.dir_relay)
                        report_error("dir_relay", dir_relay, want_res.dir_relay);
                    if (status_light !== want_res.status_light)
                        report_error("status_light", status_light, want_res.status_light);
                    if (locked_light !== want_res.locked_light)
                        report_error("locked_light", locked_light, want_res.locked_light);
                    if (moving !== want_res.moving)
                        report_error("moving", moving, want_res.moving);
                    if (cover_code !== want_res.cover_code)
                        report_error("cover_code", cover_code, want_res.cover_code);
                end
            end
        end
    end

    // receiver with random stalls and long hold-offs on request
    initial
    begin : receiver
        int hold_left;
        int holds_done;
        hold_left = 0;
        holds_done = 0;
        forever
        begin
            @(posedge clk);
            if (holds_done != holds_asked)
            begin
                holds_done++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic send_item(input logic [dms_pkg::KIND_W-1:0] k, input logic ch,
                             input logic oh, input logic bk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        kind       <= k;
        closed_hit <= ch;
        open_hit   <= oh;
        blocked    <= bk;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic write_reg(input logic [dms_pkg::REG_IDX_W-1:0] idx,
                             input logic [dms_pkg::CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic load_config(input logic [dms_pkg::CFG_W-1:0] relay,
                               input logic [dms_pkg::CFG_W-1:0] max_move,
                               input logic [dms_pkg::CFG_W-1:0] overrun,
                               input logic [dms_pkg::CFG_W-1:0] guard,
                               input logic [dms_pkg::CFG_W-1:0] blink,
                               input logic [dms_pkg::SENS_W-1:0] sens);
        in_valid <= 1'b0;
        // the last transfer is queued by the checker at the same edge
        @(posedge clk);
        while (expected_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(dms_pkg::REG_RELAY_DELAY, relay);
        write_reg(dms_pkg::REG_MAX_MOVE, max_move);
        write_reg(dms_pkg::REG_OVERRUN, overrun);
        write_reg(dms_pkg::REG_GUARD, guard);
        write_reg(dms_pkg::REG_BLINK, blink);
        write_reg(dms_pkg::REG_SENSOR_EN, {{(dms_pkg::CFG_W-dms_pkg::SENS_W){1'b0}}, sens});
        cfg_valid <= 1'b0;
    endtask

    function automatic logic chance(input int pct);
        return ($urandom_range(0, 99) < pct);
    endfunction

    function automatic logic [dms_pkg::CFG_W-1:0] pick_time(input int lo, input int hi);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            return '1;
        if (roll < 16)
            return dms_pkg::CFG_W'(lo);
        return dms_pkg::CFG_W'($urandom_range(lo, hi));
    endfunction

    task automatic random_config();
        logic [dms_pkg::SENS_W-1:0] sens;
        sens = chance(50) ? 3'b111 : dms_pkg::SENS_W'($urandom_range(0, 7));
        load_config(pick_time(0, 4), pick_time(1, 40), pick_time(0, 5), pick_time(0, 8),
                    pick_time(1, 4), sens);
    endtask

    // mostly a command followed by a run of ticks, with some noise items
    task automatic random_traffic(input int n_items);
        int sent;
        int run_len;
        logic [dms_pkg::KIND_W-1:0] k;
        sent = 0;
        while (sent < n_items)
        begin
            if (chance(10))
            begin
                k = dms_pkg::KIND_W'($urandom_range(0, 7));
                send_item(k, chance(50), chance(50), chance(50));
                if (k <= dms_pkg::KIND_PRESS)
                    sent++;
            end
            else
            begin
                k = dms_pkg::KIND_W'($urandom_range(dms_pkg::KIND_OPEN, dms_pkg::KIND_PRESS));
                send_item(k, chance(15), chance(15), chance(8));
                sent++;
                run_len = $urandom_range(0, 12);
                repeat (run_len)
                begin
                    send_item(dms_pkg::KIND_TICK, chance(15), chance(15), chance(6));
                    sent++;
                end
            end
        end
    endtask

    task automatic test_reset_defaults();
        send_item(dms_pkg::KIND_TICK, 1'b1, 1'b1, 1'b1);
        send_item(dms_pkg::KIND_OPEN, 1'b0, 1'b1, 1'b0);
        send_item(KIND_SPARE_A, 1'b0, 1'b0, 1'b0);
        send_item(KIND_SPARE_B, 1'b1, 1'b0, 1'b0);
        send_item(dms_pkg::KIND_STOP, 1'b0, 1'b0, 1'b0);
        send_item(dms_pkg::KIND_STOP, 1'b0, 1'b0, 1'b0);
        send_item(dms_pkg::KIND_PRESS, 1'b0, 1'b0, 1'b0);
    endtask

    task automatic test_run_on_and_endstops();
        load_config(16'd0, 16'd20, 16'd2, 16'd0, 16'd1, 3'b111);
        send_item(dms_pkg::KIND_CLOSE, 1'b0, 1'b0, 1'b0);
        send_item(dms_pkg::KIND_CLOSE, 1'b0, 1'b0, 1'b0);
        send_item(dms_pkg::KIND_TICK, 1'b1, 1'b0, 1'b0);
        send_item(dms_pkg::KIND_TICK, 1'b1, 1'b0, 1'b0);
        send_item(dms_pkg::KIND_TICK, 1'b0, 1'b0, 1'b0);
        send_item(dms_pkg::KIND_TICK, 1'b1, 1'b0, 1'b0);
        send_item(dms_pkg::KIND_OPEN, 1'b0, 1'b0, 1'b0);
        send_item(dms_pkg::KIND_TICK, 1'b0, 1'b1, 1'b0);
    endtask

    task automatic test_toggle_and_guard();
        load_config(16'd1, 16'd3, 16'd0, 16'd2, 16'd1, 3'b111);
        send_item(dms_pkg::KIND_TOGGLE, 1'b0, 1'b0, 1'b0);
        send_item(dms_pkg::KIND_TOGGLE, 1'b0, 1'b0, 1'b0);
        send_item(dms_pkg::KIND_PRESS, 1'b0, 1'b0, 1'b0);
        send_item(dms_pkg::KIND_TICK, 1'b0, 1'b0, 1'b0);
        send_item(dms_pkg::KIND_TICK, 1'b0, 1'b0, 1'b0);
        send_item(dms_pkg::KIND_PRESS, 1'b1, 1'b0, 1'b0);
        send_item(dms_pkg::KIND_CLOSE, 1'b0, 1'b0, 1'b1);
        send_item(dms_pkg::KIND_TOGGLE, 1'b0, 1'b1, 1'b0);
        send_item(dms_pkg::KIND_TOGGLE, 1'b0, 1'b1, 1'b0);
        send_item(dms_pkg::KIND_TICK, 1'b1, 1'b0, 1'b1);
    endtask

    // largest timer settings but for the relay delay and overrun: no limit is reached in a short run
    task automatic test_long_timers();
        load_config(16'hFFFE, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 3'b111);
        send_item(dms_pkg::KIND_OPEN, 1'b0, 1'b0, 1'b0);
        repeat (LONG_TICKS) send_item(dms_pkg::KIND_TICK, 1'b0, 1'b0, 1'b0);
        send_item(dms_pkg::KIND_PRESS, 1'b0, 1'b0, 1'b0);
    endtask

    task automatic test_random_traffic();
        for (int mode = 0; mode < 4; mode++)
        begin
            case (mode)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 75;
                    stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct = 75;
                end
                default:
                begin
                    send_idle_pct = 7;
                    stall_pct = 7;
                end
            endcase
            repeat (3)
            begin
                random_config();
                random_traffic(42);
            end
        end
    endtask

    task automatic test_output_backpressure();
        send_idle_pct = 0;
        stall_pct = 0;
        random_config();
        holds_asked++;
        random_traffic(40);
    endtask

    initial
    begin
        reset_door();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_run_on_and_endstops();
        test_toggle_and_guard();
        test_long_timers();
        test_random_traffic();
        test_output_backpressure();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_outputs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
